// ===== rtl/core/rpn_stack_calculator_unit_macros.svh =====
// assertion macros for the rpn stack calculator checker
// no dependencies; expects clk and arst_n in the scope of use
`ifndef RPN_STACK_CALCULATOR_UNIT_MACROS_SVH
`define RPN_STACK_CALCULATOR_UNIT_MACROS_SVH

// condition and consequence in the same cycle
`define RSC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequence in the cycle after the condition
`define RSC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/rsc_pkg.sv =====
// shared types, codes and constants of the rpn stack calculator
// no dependencies; used by every module of the block
`timescale 1ns / 1ps

package rsc_pkg;

	localparam int unsigned DATA_W   = 64;
	localparam int unsigned ADD_W    = DATA_W + 2;
	localparam int unsigned STEP_W   = $clog2(DATA_W);
	localparam int unsigned REQ_W    = 4;
	localparam int unsigned STATUS_W = 3;

	localparam int unsigned STACK_DEPTH_DEF = 64;
	localparam int unsigned FRAC_BITS_DEF   = 32;

	// command codes
	localparam logic [REQ_W-1:0] REQ_PUSH  = 4'd0;
	localparam logic [REQ_W-1:0] REQ_ADD   = 4'd1;
	localparam logic [REQ_W-1:0] REQ_SUB   = 4'd2;
	localparam logic [REQ_W-1:0] REQ_MUL   = 4'd3;
	localparam logic [REQ_W-1:0] REQ_DIV   = 4'd4;
	localparam logic [REQ_W-1:0] REQ_DROP  = 4'd5;
	localparam logic [REQ_W-1:0] REQ_SWAP  = 4'd6;
	localparam logic [REQ_W-1:0] REQ_BLANK = 4'd7;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
	localparam logic [STATUS_W-1:0] ST_UNDER   = 3'd1;
	localparam logic [STATUS_W-1:0] ST_UNRECOG = 3'd2;
	localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_OVF     = 3'd4;

	// saturation limits
	localparam logic [DATA_W-1:0] SAT_POS = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] SAT_NEG = {1'b1, {(DATA_W-1){1'b0}}};

	// arithmetic unit operations
	typedef logic [1:0] alu_op_t;
	localparam alu_op_t ALU_ADD = 2'd0;
	localparam alu_op_t ALU_SUB = 2'd1;
	localparam alu_op_t ALU_MUL = 2'd2;
	localparam alu_op_t ALU_DIV = 2'd3;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_req_t;

	typedef struct packed {
		logic done;
		logic sat;
	} alu_rsp_t;

endpackage

// ===== rtl/core/rsc_stack_ram.sv =====
// operand stack storage: one write port, one registered read port
// depends on rsc_pkg for the data width
`timescale 1ns / 1ps

module rsc_stack_ram
	import rsc_pkg::*;
#(
	parameter int unsigned DEPTH = STACK_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DATA_W-1:0]        wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DATA_W-1:0]        rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/rsc_alu.sv =====
// shared arithmetic unit: one adder used for add, subtract, and the
// one-bit-per-cycle shift-add multiply and restoring divide; uses rsc_pkg
`timescale 1ns / 1ps

module rsc_alu
	import rsc_pkg::*;
#(
	parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  alu_req_t          req,
	input  logic [DATA_W-1:0] x,
	input  logic [DATA_W-1:0] y,
	output alu_rsp_t          rsp,
	output logic [DATA_W-1:0] result
);

	localparam logic [2:0] A_IDLE = 3'd0;
	localparam logic [2:0] A_MAG  = 3'd1;
	localparam logic [2:0] A_LOAD = 3'd2;
	localparam logic [2:0] A_RUN  = 3'd3;
	localparam logic [2:0] A_FIN  = 3'd4;

	logic [2:0]          state_q;
	logic                done_q;
	alu_op_t             op_q;
	logic [DATA_W-1:0]   x_q;
	logic [DATA_W-1:0]   y_q;
	logic [DATA_W-1:0]   mx_q;
	logic [DATA_W-1:0]   my_q;
	logic                neg_q;
	logic [DATA_W-1:0]   a_q;
	logic [DATA_W-1:0]   hi_q;
	logic [DATA_W-1:0]   lo_q;
	logic                ovf_q;
	logic [STEP_W-1:0]   step_q;
	logic [DATA_W-1:0]   result_q;
	logic                sat_q;

	logic [ADD_W-1:0]    add_a;
	logic [ADD_W-1:0]    add_b;
	logic                add_sub;
	logic [ADD_W-1:0]    add_res;
	logic                as_ovf;
	logic                div_ge;
	logic                mag_ready;
	logic [2*DATA_W-1:0] num;
	logic [2*DATA_W-1:0] prod;
	logic [DATA_W-1:0]   fin_mag;
	logic                fin_over;

	// operand selection for the shared adder
	always_comb begin
		add_a   = '0;
		add_b   = '0;
		add_sub = 1'b0;
		unique case (state_q)
			A_MAG: begin
				add_a   = {{2{x_q[DATA_W-1]}}, x_q};
				add_b   = {{2{y_q[DATA_W-1]}}, y_q};
				add_sub = (op_q == ALU_SUB);
			end
			A_RUN: begin
				if (op_q == ALU_MUL) begin
					add_a = {2'b00, hi_q};
					add_b = lo_q[0] ? {2'b00, a_q} : '0;
				end else begin
					add_a   = {1'b0, hi_q, lo_q[DATA_W-1]};
					add_b   = {2'b00, a_q};
					add_sub = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign add_res = add_a + (add_b ^ {ADD_W{add_sub}}) + ADD_W'(add_sub);

	// exact sum fits in one more bit; overflow when the two top bits differ
	assign as_ovf = add_res[DATA_W] ^ add_res[DATA_W-1];
	assign div_ge = ~add_res[ADD_W-1];

	// add, subtract and divide by zero finish straight after the operands
	assign mag_ready = (op_q == ALU_ADD) || (op_q == ALU_SUB) ||
			((op_q == ALU_DIV) && (y_q == '0));

	// scaled dividend and rescaled product
	assign num  = {{DATA_W{1'b0}}, mx_q} << FRAC_BITS;
	assign prod = {hi_q, lo_q} >> FRAC_BITS;

	// magnitude and range at the end of a multiply or divide
	always_comb begin
		if (op_q == ALU_MUL) begin
			fin_mag  = prod[DATA_W-1:0];
			fin_over = |prod[2*DATA_W-1:DATA_W];
		end else begin
			fin_mag  = lo_q;
			fin_over = ovf_q;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				A_IDLE: begin
					if (req.start) begin
						state_q <= A_MAG;
					end
				end
				A_MAG: begin
					if (mag_ready) begin
						state_q <= A_IDLE;
						done_q  <= 1'b1;
					end else begin
						state_q <= A_LOAD;
					end
				end
				A_LOAD: begin
					state_q <= A_RUN;
				end
				A_RUN: begin
					if (step_q == STEP_W'(DATA_W - 1)) begin
						state_q <= A_FIN;
					end
				end
				A_FIN: begin
					state_q <= A_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= A_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			A_IDLE: begin
				if (req.start) begin
					op_q <= req.op;
					x_q  <= x;
					y_q  <= y;
				end
			end
			A_MAG: begin
				neg_q <= x_q[DATA_W-1] ^ y_q[DATA_W-1];
				mx_q  <= x_q[DATA_W-1] ? (DATA_W'(0) - x_q) : x_q;
				my_q  <= y_q[DATA_W-1] ? (DATA_W'(0) - y_q) : y_q;
				if (op_q == ALU_ADD || op_q == ALU_SUB) begin
					sat_q <= as_ovf;
					if (as_ovf) begin
						result_q <= add_res[DATA_W] ? SAT_NEG : SAT_POS;
					end else begin
						result_q <= add_res[DATA_W-1:0];
					end
				end else begin
					// divide by zero saturates by the sign of the dividend
					sat_q    <= 1'b1;
					result_q <= x_q[DATA_W-1] ? SAT_NEG : SAT_POS;
				end
			end
			A_LOAD: begin
				step_q <= '0;
				if (op_q == ALU_MUL) begin
					a_q  <= mx_q;
					hi_q <= '0;
					lo_q <= my_q;
				end else begin
					a_q   <= my_q;
					hi_q  <= num[2*DATA_W-1:DATA_W];
					lo_q  <= num[DATA_W-1:0];
					// upper quotient half non-zero when the top half reaches the divisor
					ovf_q <= (num[2*DATA_W-1:DATA_W] >= my_q);
				end
			end
			A_RUN: begin
				step_q <= step_q + STEP_W'(1);
				if (op_q == ALU_MUL) begin
					hi_q <= add_res[DATA_W:1];
					lo_q <= {add_res[0], lo_q[DATA_W-1:1]};
				end else begin
					hi_q <= div_ge ? add_res[DATA_W-1:0] : {hi_q[DATA_W-2:0], lo_q[DATA_W-1]};
					lo_q <= {lo_q[DATA_W-2:0], div_ge};
				end
			end
			A_FIN: begin
				if (neg_q) begin
					sat_q    <= fin_over || (fin_mag > SAT_NEG);
					result_q <= (fin_over || (fin_mag > SAT_NEG)) ? SAT_NEG :
							(DATA_W'(0) - fin_mag);
				end else begin
					sat_q    <= fin_over || fin_mag[DATA_W-1];
					result_q <= (fin_over || fin_mag[DATA_W-1]) ? SAT_POS : fin_mag;
				end
			end
			default: begin
			end
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.sat  = sat_q;
	assign result   = result_q;

endmodule

// ===== rtl/core/rpn_stack_calculator_unit.sv =====
// Reverse Polish calculator on a stack of signed fixed-point values. Each
// accepted command yields exactly one result: the top of the stack, its valid
// mark and a status. One command is handled at a time; the input stalls until
// the result has been placed in the output register, and the next command may
// transfer while that result still waits. Push, drop, no-op, unrecognised
// codes and any command that underflows take the shortest path; swap adds
// two stack reads and two writes, add, subtract and divide by zero add the
// two reads, an rsc_alu operation and a write, and multiply and divide also
// run the 64 one-bit steps of the shared adder in rsc_alu. Stack reads go
// through the single registered read port of rsc_stack_ram.
// Depends on rsc_pkg, rsc_stack_ram and rsc_alu.
`timescale 1ns / 1ps

module rpn_stack_calculator_unit
	import rsc_pkg::*;
#(
	parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEF,
	parameter int unsigned FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [REQ_W-1:0]    req_type,
	input  logic signed [DATA_W-1:0] push_value,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [DATA_W-1:0] top_value,
	output logic                top_valid,
	output logic [STATUS_W-1:0] status
);

	localparam int unsigned AW = $clog2(STACK_DEPTH);
	localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_EXEC  = 4'd1;
	localparam logic [3:0] S_RDY   = 4'd2;
	localparam logic [3:0] S_RDX   = 4'd3;
	localparam logic [3:0] S_OPS   = 4'd4;
	localparam logic [3:0] S_SWP2  = 4'd5;
	localparam logic [3:0] S_ALU   = 4'd6;
	localparam logic [3:0] S_RDTOP = 4'd7;
	localparam logic [3:0] S_FIN   = 4'd8;

	logic [3:0]          state_q;
	logic [3:0]          state_d;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       count_d;
	logic [STATUS_W-1:0] status_q;
	logic [STATUS_W-1:0] status_d;
	logic [REQ_W-1:0]    req_q;
	logic [DATA_W-1:0]   push_q;
	logic [DATA_W-1:0]   x_q;
	logic [DATA_W-1:0]   y_q;
	logic                out_valid_q;
	logic [DATA_W-1:0]   top_value_q;
	logic                top_valid_q;
	logic [STATUS_W-1:0] out_status_q;

	logic [CW-1:0]       top_idx;
	logic [CW-1:0]       sec_idx;
	logic                full;
	logic                two_op;
	logic                out_load;

	logic                mem_we;
	logic [AW-1:0]       mem_waddr;
	logic [DATA_W-1:0]   mem_wdata;
	logic                mem_re;
	logic [AW-1:0]       mem_raddr;
	logic [DATA_W-1:0]   mem_rdata;

	alu_req_t            alu_req;
	alu_rsp_t            alu_rsp;
	logic [DATA_W-1:0]   alu_result;
	alu_op_t             alu_op;

	rsc_stack_ram #(
		.DEPTH (STACK_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	rsc_alu #(
		.FRAC_BITS (FRAC_BITS)
	) u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.x      (x_q),
		.y      (y_q),
		.rsp    (alu_rsp),
		.result (alu_result)
	);

	// stack positions of the top and second entries
	assign top_idx = count_q - CW'(1);
	assign sec_idx = count_q - CW'(2);
	assign full    = (count_q == CW'(STACK_DEPTH));
	assign two_op  = (req_q == REQ_ADD) || (req_q == REQ_SUB) || (req_q == REQ_MUL) ||
			(req_q == REQ_DIV) || (req_q == REQ_SWAP);

	// command to arithmetic operation
	always_comb begin
		unique case (req_q)
			REQ_ADD: alu_op = ALU_ADD;
			REQ_SUB: alu_op = ALU_SUB;
			REQ_MUL: alu_op = ALU_MUL;
			default: alu_op = ALU_DIV;
		endcase
	end

	// stack memory accesses per step
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = count_q[AW-1:0];
		mem_wdata = push_q;
		mem_re    = 1'b0;
		mem_raddr = top_idx[AW-1:0];
		unique case (state_q)
			S_EXEC: begin
				if (req_q == REQ_PUSH && !full) begin
					mem_we = 1'b1;
				end
				if (two_op && count_q >= CW'(2)) begin
					mem_re = 1'b1;
				end
			end
			S_RDY: begin
				mem_re    = 1'b1;
				mem_raddr = sec_idx[AW-1:0];
			end
			S_OPS: begin
				if (req_q == REQ_SWAP) begin
					mem_we    = 1'b1;
					mem_waddr = sec_idx[AW-1:0];
					mem_wdata = y_q;
				end
			end
			S_SWP2: begin
				mem_we    = 1'b1;
				mem_waddr = top_idx[AW-1:0];
				mem_wdata = x_q;
			end
			S_ALU: begin
				if (alu_rsp.done) begin
					mem_we    = 1'b1;
					mem_waddr = sec_idx[AW-1:0];
					mem_wdata = alu_result;
				end
			end
			S_RDTOP: begin
				mem_re = (count_q != '0);
			end
			default: begin
			end
		endcase
	end

	// command sequencer
	always_comb begin
		state_d       = state_q;
		count_d       = count_q;
		status_d      = status_q;
		alu_req.start = 1'b0;
		alu_req.op    = alu_op;
		unique case (state_q)
			S_IDLE: begin
				status_d = ST_OK;
				if (in_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_RDTOP;
				priority if (req_q == REQ_PUSH) begin
					if (full) begin
						status_d = ST_FULL;
					end else begin
						count_d = count_q + CW'(1);
					end
				end else if (two_op) begin
					if (count_q == '0) begin
						status_d = ST_UNDER;
					end else if (count_q == CW'(1)) begin
						// a lone operand is consumed
						count_d  = '0;
						status_d = ST_UNDER;
					end else begin
						state_d = S_RDY;
					end
				end else if (req_q == REQ_DROP) begin
					if (count_q == '0) begin
						status_d = ST_UNDER;
					end else begin
						count_d = count_q - CW'(1);
					end
				end else if (req_q == REQ_BLANK) begin
					status_d = ST_OK;
				end else begin
					status_d = ST_UNRECOG;
				end
			end
			S_RDY: begin
				state_d = S_RDX;
			end
			S_RDX: begin
				state_d = S_OPS;
			end
			S_OPS: begin
				if (req_q == REQ_SWAP) begin
					state_d = S_SWP2;
				end else begin
					alu_req.start = 1'b1;
					state_d       = S_ALU;
				end
			end
			S_SWP2: begin
				state_d = S_RDTOP;
			end
			S_ALU: begin
				if (alu_rsp.done) begin
					count_d  = count_q - CW'(1);
					status_d = alu_rsp.sat ? ST_OVF : ST_OK;
					state_d  = S_RDTOP;
				end
			end
			S_RDTOP: begin
				state_d = S_FIN;
			end
			S_FIN: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign out_load = (state_q == S_FIN) && (!out_valid_q || !out_stall);

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// command, operand and result registers
	always_ff @(posedge clk) begin
		status_q <= status_d;
		if (state_q == S_IDLE && in_valid) begin
			req_q  <= req_type;
			push_q <= push_value;
		end
		if (state_q == S_RDY) begin
			y_q <= mem_rdata;
		end
		if (state_q == S_RDX) begin
			x_q <= mem_rdata;
		end
		if (out_load) begin
			top_value_q  <= (count_q != '0) ? mem_rdata : '0;
			top_valid_q  <= (count_q != '0);
			out_status_q <= status_q;
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign top_value = top_value_q;
	assign top_valid = top_valid_q;
	assign status    = out_status_q;

endmodule

// ===== rtl/core/rsc_checker.sv =====
// port-level checks for the rpn stack calculator, bound to the top level
// depends on rsc_pkg and rpn_stack_calculator_unit_macros.svh
`timescale 1ns / 1ps
`include "rpn_stack_calculator_unit_macros.svh"

module rsc_checker
	import rsc_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input logic [DATA_W-1:0]   top_value,
	input logic                top_valid,
	input logic [STATUS_W-1:0] status
);

	// a stalled result stays put
	`RSC_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(top_value) && $stable(top_valid) && $stable(status),
		"result changed while stalled")

	// one command at a time: busy right after an input transfer
	`RSC_ASSERT_NEXT(a_busy_after_transfer, in_valid && !in_stall, in_stall,
		"input taken while a command is in progress")

	// an empty stack reports a zero top
	`RSC_ASSERT_SAME(a_empty_zero, out_valid && !top_valid, top_value == '0,
		"empty stack with non-zero top")

	// a refused push leaves a full, non-empty stack
	`RSC_ASSERT_SAME(a_full_has_top, out_valid && (status == ST_FULL), top_valid,
		"stack full reported on an empty stack")

	// only defined status codes leave the block
	`RSC_ASSERT_SAME(a_status_code, out_valid,
		(status == ST_OK) || (status == ST_UNDER) || (status == ST_UNRECOG) ||
		(status == ST_FULL) || (status == ST_OVF),
		"undefined status code")

endmodule

bind rpn_stack_calculator_unit rsc_checker u_rsc_checker (.*);
